// File: rtl/core/decision_stump_threshold_search_macros.svh
`ifndef DECISION_STUMP_THRESHOLD_SEARCH_MACROS_SVH
`define DECISION_STUMP_THRESHOLD_SEARCH_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DSTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define DSTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/core/dsts_pkg.sv
package dsts_pkg;
   localparam int DEF_MAX_SAMPLES = 1024;
   localparam int DEF_WEIGHT_BITS = 16;
   localparam int DEF_VALUE_BITS  = 24;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_MRG_SETUP,
      ST_MRG_RD,
      ST_MRG_WAIT,
      ST_MRG_CMP,
      ST_MRG_NEXT,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SCAN_ACC,
      ST_SCAN_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic init;
      logic mrg_setup;
      logic mrg_rd;
      logic mrg_cmp;
      logic mrg_next;
      logic scan_rd;
      logic scan_acc;
      logic scan_cmp;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic init_done;
      logic run_done;
      logic pass_done;
      logic sort_done;
      logic scan_done;
   } sts_type;
endpackage

// File: rtl/core/dsts_ctrl.sv
module dsts_ctrl
   import dsts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    last_in,
   input  sts_type sts,
   output logic    busy,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (last_in) state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            if (sts.init_done) state_in = ST_SCAN_RD;
            else state_in = ST_MRG_SETUP;
         end
         ST_MRG_SETUP: begin
            cmd.mrg_setup = 1'b1;
            state_in = ST_MRG_RD;
         end
         ST_MRG_RD: begin
            cmd.mrg_rd = 1'b1;
            state_in = ST_MRG_WAIT;
         end
         ST_MRG_WAIT: state_in = ST_MRG_CMP;
         ST_MRG_CMP: begin
            cmd.mrg_cmp = 1'b1;
            if (sts.run_done) state_in = ST_MRG_NEXT;
            else state_in = ST_MRG_RD;
         end
         ST_MRG_NEXT: begin
            cmd.mrg_next = 1'b1;
            if (sts.sort_done) state_in = ST_SCAN_RD;
            else state_in = ST_MRG_SETUP;
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: state_in = ST_SCAN_ACC;
         ST_SCAN_ACC: begin
            cmd.scan_acc = 1'b1;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            if (sts.scan_done) state_in = ST_DONE;
            else state_in = ST_SCAN_RD;
         end
         ST_DONE: begin
            cmd.done = 1'b1;
            state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end
endmodule

// File: rtl/core/dsts_dp.sv
module dsts_dp
   import dsts_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
   parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic                         label_in,
   input  logic [WEIGHT_BITS-1:0]       weight_in,
   input  logic signed [VALUE_BITS-1:0] value_in,
   output sts_type                      sts,
   output logic                         rsp_strobe,
   output logic signed [VALUE_BITS-1:0] rsp_threshold,
   output logic                         rsp_polarity
);
   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int PW = (CW > 1) ? CW + 1 : 2;
   localparam int SW = WEIGHT_BITS + CW;
   localparam int DW = 1 + WEIGHT_BITS + VALUE_BITS;

   logic [DW-1:0] smem [MAX_SAMPLES];
   logic [AW-1:0] ord_a [MAX_SAMPLES];
   logic [AW-1:0] ord_b [MAX_SAMPLES];

   logic [CW-1:0] count_ff, count_in;
   logic          bank_ff;
   logic [PW-1:0] width_ff, lo_ff, p_ff, q_ff, mid_ff, hi_ff, k_ff;
   logic [AW-1:0] idx_p_ff, idx_q_ff;
   logic [DW-1:0] dat_p_ff, dat_q_ff;
   logic [SW-1:0] tneg_ff, tpos_ff, sneg_ff, spos_ff, best_ff;
   logic          have_ff;
   logic signed [VALUE_BITS-1:0] bval_ff;
   logic          bpol_ff;
   logic          strobe_ff;

   logic [PW-1:0] cnt_p, mid_c, hi_c, lo_next, w2;
   logic          take_q, p_ok, q_ok;
   logic signed [VALUE_BITS-1:0] vp, vq;
   logic [SW-1:0] eneg, epos, sneg_n, spos_n;

   assign cnt_p = PW'(count_ff);
   assign w2 = width_ff << 1;
   assign mid_c = (lo_ff + width_ff < cnt_p) ? lo_ff + width_ff : cnt_p;
   assign hi_c = (lo_ff + w2 < cnt_p) ? lo_ff + w2 : cnt_p;
   assign lo_next = lo_ff + w2;
   assign p_ok = p_ff < mid_ff;
   assign q_ok = q_ff < hi_ff;
   assign vp = dat_p_ff[VALUE_BITS-1:0];
   assign vq = dat_q_ff[VALUE_BITS-1:0];
   assign take_q = q_ok && (!p_ok || (vq < vp));

   assign sts.init_done = cnt_p <= PW'(1);
   assign sts.run_done = (k_ff + PW'(1)) >= hi_ff;
   assign sts.pass_done = lo_next >= cnt_p;
   assign sts.sort_done = sts.pass_done && (w2 >= cnt_p);
   assign sts.scan_done = (k_ff + PW'(1)) >= cnt_p;

   always_comb begin
      count_in = count_ff;
      if (cmd.load && (count_ff < CW'(MAX_SAMPLES))) count_in = count_ff + CW'(1);
      if (cmd.done) count_in = '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CW'(MAX_SAMPLES))) begin
         smem[count_ff[AW-1:0]] <= {label_in, weight_in, value_in};
      end
      dat_p_ff <= smem[idx_p_ff];
      dat_q_ff <= smem[idx_q_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CW'(MAX_SAMPLES))) begin
         ord_a[count_ff[AW-1:0]] <= count_ff[AW-1:0];
      end
      if (cmd.mrg_rd) begin
         idx_p_ff <= bank_ff ? ord_b[p_ff[AW-1:0]] : ord_a[p_ff[AW-1:0]];
         idx_q_ff <= bank_ff ? ord_b[q_ff[AW-1:0]] : ord_a[q_ff[AW-1:0]];
      end
      if (cmd.scan_rd) begin
         idx_p_ff <= bank_ff ? ord_b[k_ff[AW-1:0]] : ord_a[k_ff[AW-1:0]];
      end
      if (cmd.mrg_cmp) begin
         if (bank_ff) ord_a[k_ff[AW-1:0]] <= take_q ? idx_q_ff : idx_p_ff;
         else ord_b[k_ff[AW-1:0]] <= take_q ? idx_q_ff : idx_p_ff;
      end
   end

   assign spos_n = dat_p_ff[DW-1] ? spos_ff + SW'(dat_p_ff[DW-2 -: WEIGHT_BITS]) : spos_ff;
   assign sneg_n = dat_p_ff[DW-1] ? sneg_ff : sneg_ff + SW'(dat_p_ff[DW-2 -: WEIGHT_BITS]);
   assign eneg = spos_ff + (tneg_ff - sneg_ff);
   assign epos = sneg_ff + (tpos_ff - spos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         strobe_ff <= 1'b0;
         bank_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         strobe_ff <= cmd.done;
         if (cmd.init) bank_ff <= 1'b0;
         if (cmd.mrg_next && sts.pass_done) bank_ff <= ~bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CW'(MAX_SAMPLES))) begin
         if (count_ff == '0) begin
            tpos_ff <= label_in ? SW'(weight_in) : '0;
            tneg_ff <= label_in ? '0 : SW'(weight_in);
         end else begin
            if (label_in) tpos_ff <= tpos_ff + SW'(weight_in);
            else tneg_ff <= tneg_ff + SW'(weight_in);
         end
      end
      if (cmd.init) begin
         width_ff <= PW'(1);
         lo_ff <= '0;
         k_ff <= '0;
         sneg_ff <= '0;
         spos_ff <= '0;
         have_ff <= 1'b0;
      end
      if (cmd.mrg_setup) begin
         mid_ff <= mid_c;
         hi_ff <= hi_c;
         p_ff <= lo_ff;
         q_ff <= mid_c;
         k_ff <= lo_ff;
      end
      if (cmd.mrg_cmp) begin
         k_ff <= k_ff + PW'(1);
         if (take_q) q_ff <= q_ff + PW'(1);
         else p_ff <= p_ff + PW'(1);
      end
      if (cmd.mrg_next) begin
         if (sts.pass_done) begin
            lo_ff <= '0;
            width_ff <= w2;
         end else begin
            lo_ff <= lo_next;
         end
         if (sts.sort_done) k_ff <= '0;
      end
      if (cmd.scan_acc) begin
         spos_ff <= spos_n;
         sneg_ff <= sneg_n;
      end
      if (cmd.scan_cmp) begin
         k_ff <= k_ff + PW'(1);
         if (!have_ff || eneg < best_ff) begin
            have_ff <= 1'b1;
            best_ff <= eneg;
            bval_ff <= vp;
            bpol_ff <= 1'b0;
         end else if (epos < best_ff) begin
            best_ff <= epos;
            bval_ff <= vp;
            bpol_ff <= 1'b1;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_threshold = bval_ff;
   assign rsp_polarity = bpol_ff;
endmodule

// File: rtl/core/decision_stump_threshold_search.sv
// Decision stump threshold search.
// Input channel: an item (req_label, req_weight, req_feature_value,
// req_last) is taken at a rising edge with start high and busy low.
// Items are taken one per cycle while collecting; a full store drops items.
// An item with req_last high ends the set: busy rises and the block sorts
// the stored samples with a stable bottom-up merge sort held in two index
// memories, then scans them once for the least weighted error.
// For n samples the sort makes ceil(log2 n) passes; in a pass each sample
// goes through read, wait and compare states, each merged run through setup
// and next states. The scan takes each sample through read, wait, accumulate
// and compare states. rsp_strobe is registered from the done state, and busy
// falls as it rises, so the next set may begin while the result is shown.
// The single result appears on rsp_threshold and rsp_polarity, marked by
// rsp_strobe high for a single cycle; the receiver cannot stall it.
// Reset is synchronous, active high, and empties the sample store;
// no clearing pass is needed, as only written entries are read.
`include "decision_stump_threshold_search_macros.svh"
module decision_stump_threshold_search
   import dsts_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
   parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_label,
   input  logic [WEIGHT_BITS-1:0]       req_weight,
   input  logic signed [VALUE_BITS-1:0] req_feature_value,
   input  logic                         req_last,
   output logic                         rsp_strobe,
   output logic signed [VALUE_BITS-1:0] rsp_threshold,
   output logic                         rsp_polarity
);
   cmd_type cmd;
   sts_type sts;

   dsts_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .last_in(req_last),
      .sts(sts), .busy(busy), .cmd(cmd)
   );

   dsts_dp #(
      .MAX_SAMPLES(MAX_SAMPLES), .WEIGHT_BITS(WEIGHT_BITS), .VALUE_BITS(VALUE_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .label_in(req_label),
      .weight_in(req_weight), .value_in(req_feature_value), .sts(sts),
      .rsp_strobe(rsp_strobe), .rsp_threshold(rsp_threshold),
      .rsp_polarity(rsp_polarity)
   );

   `DSTS_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, !$past(rsp_strobe), "double result")
   `DSTS_ASSERT_NEXT(a_last_busy, clock, reset, start && !busy && req_last, busy, "not busy after last")
   `DSTS_ASSERT_IMP(a_no_strobe_idle, clock, reset, rsp_strobe, $past(busy), "result without search")
endmodule

// File: tb/dsts_checker.sv
`timescale 1ns / 100ps
module dsts_checker
   import dsts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_label,
   input  logic [15:0]        req_weight,
   input  logic signed [23:0] req_feature_value,
   input  logic               req_last,
   input  logic               rsp_strobe,
   input  logic signed [23:0] rsp_threshold,
   input  logic               rsp_polarity,
   output int                 fail_count,
   output int                 stumps_pending
);
   localparam int DEPTH = DEF_MAX_SAMPLES;

   typedef struct {
      logic signed [23:0] threshold;
      logic               polarity;
   } stump_type;

   logic               held_label [DEPTH];
   logic [15:0]        held_weight [DEPTH];
   logic signed [23:0] held_value [DEPTH];
   int                 held_count;
   stump_type          stumps_due [$];

   function automatic stump_type best_stump(int n);
      int                  rank [DEPTH];
      int                  j;
      int                  key;
      longint unsigned     tot_neg, tot_pos, run_neg, run_pos, err_neg, err_pos, best_err;
      stump_type           pick;
      tot_neg = 0;
      tot_pos = 0;
      run_neg = 0;
      run_pos = 0;
      best_err = 0;
      pick.threshold = '0;
      pick.polarity = 1'b0;
      for (int i = 0; i < n; i++) begin
         key = i;
         j = i;
         while (j > 0 && held_value[rank[j-1]] > held_value[key]) begin
            rank[j] = rank[j-1];
            j--;
         end
         rank[j] = key;
      end
      for (int i = 0; i < n; i++) begin
         if (held_label[rank[i]]) tot_pos += held_weight[rank[i]];
         else tot_neg += held_weight[rank[i]];
      end
      for (int i = 0; i < n; i++) begin
         if (held_label[rank[i]]) run_pos += held_weight[rank[i]];
         else run_neg += held_weight[rank[i]];
         err_neg = run_pos + (tot_neg - run_neg);
         err_pos = run_neg + (tot_pos - run_pos);
         if (i == 0 || err_neg < best_err) begin
            best_err = err_neg;
            pick.threshold = held_value[rank[i]];
            pick.polarity = 1'b0;
         end else if (err_pos < best_err) begin
            best_err = err_pos;
            pick.threshold = held_value[rank[i]];
            pick.polarity = 1'b1;
         end
      end
      return pick;
   endfunction

   always @(posedge clock) begin
      stump_type want;
      if (reset) begin
         held_count = 0;
         stumps_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (stumps_due.size() == 0) begin
               $error("result with no item waiting: threshold %0d polarity %0d",
                      rsp_threshold, rsp_polarity);
               fail_count++;
            end else begin
               want = stumps_due.pop_front();
               if (rsp_threshold !== want.threshold) begin
                  $error("threshold: expected %0d, got %0d", want.threshold, rsp_threshold);
                  fail_count++;
               end
               if (rsp_polarity !== want.polarity) begin
                  $error("polarity: expected %0d, got %0d", want.polarity, rsp_polarity);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            if (held_count < DEPTH) begin
               held_label[held_count] = req_label;
               held_weight[held_count] = req_weight;
               held_value[held_count] = req_feature_value;
               held_count++;
            end
            if (req_last) begin
               stumps_due = {stumps_due, best_stump(held_count)};
               held_count = 0;
            end
         end
      end
      stumps_pending <= stumps_due.size();
   end
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import dsts_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_label = 1'b0;
   logic [15:0]        req_weight = '0;
   logic signed [23:0] req_feature_value = '0;
   logic               req_last = 1'b0;
   logic               rsp_strobe;
   logic signed [23:0] rsp_threshold;
   logic               rsp_polarity;
   logic               item_taken = 1'b0;
   int                 fail_count;
   int                 stumps_pending;
   int                 cycle_count = 0;
   int                 burst_left = 0;

   always #6 clock = ~clock;

   decision_stump_threshold_search dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_label(req_label), .req_weight(req_weight),
      .req_feature_value(req_feature_value), .req_last(req_last),
      .rsp_strobe(rsp_strobe), .rsp_threshold(rsp_threshold),
      .rsp_polarity(rsp_polarity)
   );

   dsts_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_label(req_label), .req_weight(req_weight),
      .req_feature_value(req_feature_value), .req_last(req_last),
      .rsp_strobe(rsp_strobe), .rsp_threshold(rsp_threshold),
      .rsp_polarity(rsp_polarity),
      .fail_count(fail_count), .stumps_pending(stumps_pending)
   );

   always @(posedge clock) begin
      item_taken <= start && !busy && !reset;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("decision_stump_threshold_search verification failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_sample(logic lab, logic [15:0] wt, logic signed [23:0] fv, logic fin);
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      start = 1'b1;
      req_label = lab;
      req_weight = wt;
      req_feature_value = fv;
      req_last = fin;
      do @(negedge clock); while (!item_taken);
      start = 1'b0;
   endtask

   function automatic logic signed [23:0] pick_value();
      case ($urandom_range(0, 3))
         0: return 24'(int'($urandom_range(0, 7)) - 4);
         1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic send_set(int n, int value_mode);
      logic signed [23:0] fv;
      for (int i = 0; i < n; i++) begin
         case (value_mode)
            0: fv = pick_value();
            1: fv = 24'sd5;
            default: fv = 24'($urandom());
         endcase
         send_sample(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), fv,
                     i == n - 1);
      end
   endtask

   initial begin
      int set_size;
      repeat (2) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      send_sample(1'b1, 16'hFFFF, 24'sh800000, 1'b1);
      send_sample(1'b0, 16'hFFFF, 24'sh7FFFFF, 1'b1);
      send_sample(1'b0, 16'h0000, 24'sh000000, 1'b0);
      send_sample(1'b1, 16'h0000, 24'shFFFFFF, 1'b1);
      send_sample(1'b1, 16'h8000, 24'sh7FFFFF, 1'b0);
      send_sample(1'b0, 16'h0001, 24'sh800000, 1'b0);
      send_sample(1'b1, 16'h7FFF, 24'sh000001, 1'b1);
      send_set(6, 1);
      send_set(6, 0);
      while (stumps_pending != 0) @(negedge clock);
      for (int sent = 0; sent < 731; sent += set_size) begin
         set_size = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                 : $urandom_range(1, 12);
         send_set(set_size, $urandom_range(0, 2));
         if ($urandom_range(0, 9) == 0)
            while (stumps_pending != 0) @(negedge clock);
      end
      while (stumps_pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0 && stumps_pending == 0)
         $display("decision_stump_threshold_search verification clean");
      else
         $display("decision_stump_threshold_search verification failed");
      $finish;
   end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/dsts_pkg.sv
rtl/core/dsts_ctrl.sv
rtl/core/dsts_dp.sv
rtl/core/decision_stump_threshold_search.sv
tb/dsts_checker.sv
tb/tb_top.sv
